// ----- rtl/two_of_three_set_count_top_assert.svh -----
// Assertion macros for the two-of-three set counter.
// Included by the modules that check their own control logic.
`ifndef TWO_OF_THREE_SET_COUNT_TOP_ASSERT_SVH
`define TWO_OF_THREE_SET_COUNT_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TOT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tot_pkg.sv -----
// Shared types and constants of the two-of-three set counter.
// Used by tot_list_ram and two_of_three_set_count_top; depends on nothing.
package tot_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int VALUE_W        = 32;
    localparam int MODE_W         = 2;
    localparam int COUNT_W        = 6;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [MODE_W-1:0]         t_mode;
    typedef logic [COUNT_W-1:0]        t_count;

    localparam t_mode  MODE_APPEND_A = 2'd0;
    localparam t_mode  MODE_APPEND_B = 2'd1;
    localparam t_mode  MODE_APPEND_C = 2'd2;
    localparam t_mode  MODE_COMPUTE  = 2'd3;

    localparam t_count COUNT_MAX = {COUNT_W{1'b1}};

endpackage

// ----- rtl/tot_list_ram.sv -----
// One list store: a single-port-write, single-port-read synchronous RAM.
// Read data is registered. Depends on tot_pkg.
module tot_list_ram #(
    parameter int LIST_DEPTH = tot_pkg::LIST_DEPTH_DEF,
    parameter int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  tot_pkg::t_value       i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output tot_pkg::t_value       o_rdata
);

    tot_pkg::t_value r_mem [LIST_DEPTH];
    tot_pkg::t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/two_of_three_set_count_top.sv -----
// Top level of the two-of-three set counter.
// Depends on tot_pkg, tot_list_ram and two_of_three_set_count_top_assert.svh.
//
// Usage:
// A transaction is taken at a rising edge where start is high and busy is low.
// Modes 0, 1 and 2 append i_value to list A, B or C. An append leaves busy
// low, so appends may follow back to back. An append to a full list is
// dropped and remembered in the overflow flag.
// Mode 3 computes the number of distinct values found in exactly two lists.
// busy rises the next cycle and stays high while the three list RAMs are
// walked. For every element of A, and then of B, the element is fetched and
// one entry of each RAM is compared per cycle, with the scans over all three
// RAMs sharing one read address. The result appears on o_pair_count and
// o_overflow, marked by o_result_valid for exactly one cycle, in the cycle
// that busy falls. The receiver cannot stall it. The compute empties all
// lists and clears the overflow flag.
// Reset empties the lists and clears the flag; RAM contents are not cleared.
module two_of_three_set_count_top #(
    parameter int LIST_DEPTH = tot_pkg::LIST_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tot_pkg::t_mode       i_mode,
    input  tot_pkg::t_value      i_value,
    output logic                 o_result_valid,
    output tot_pkg::t_count      o_pair_count,
    output logic                 o_overflow
);

    `include "two_of_three_set_count_top_assert.svh"

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(LIST_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_LOAD,
        S_SCAN,
        S_TALLY,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [LW-1:0]   r_len_a;
    logic [LW-1:0]   r_len_b;
    logic [LW-1:0]   r_len_c;
    logic            r_drop;
    logic            r_phase;
    logic [LW-1:0]   r_i;
    logic [LW-1:0]   r_k;
    tot_pkg::t_value r_x;
    logic            r_pv;
    logic            r_pen_a;
    logic            r_pen_b;
    logic            r_pen_c;
    logic            r_hit_a;
    logic            r_hit_b;
    logic            r_hit_c;
    tot_pkg::t_count r_total;
    logic            r_out_valid;
    tot_pkg::t_count r_out_count;
    logic            r_out_ovf;

    logic            accept;
    logic            we_a;
    logic            we_b;
    logic            we_c;
    logic [LW-1:0]   lim_a;
    logic [LW-1:0]   lim_b;
    logic [LW-1:0]   lim_c;
    logic [LW-1:0]   max_ab;
    logic [LW-1:0]   scan_len;
    logic            outer_done;
    logic            pair_hit;
    logic [AW-1:0]   rd_addr;
    tot_pkg::t_value rdata_a;
    tot_pkg::t_value rdata_b;
    tot_pkg::t_value rdata_c;

    assign accept = start && (r_state == S_IDLE);
    assign we_a   = accept && (i_mode == tot_pkg::MODE_APPEND_A) && (r_len_a != DEPTH_L);
    assign we_b   = accept && (i_mode == tot_pkg::MODE_APPEND_B) && (r_len_b != DEPTH_L);
    assign we_c   = accept && (i_mode == tot_pkg::MODE_APPEND_C) && (r_len_c != DEPTH_L);

    assign lim_a      = r_phase ? r_len_a : r_i;
    assign lim_b      = r_phase ? r_i : r_len_b;
    assign lim_c      = r_len_c;
    assign max_ab     = (lim_a > lim_b) ? lim_a : lim_b;
    assign scan_len   = (max_ab > lim_c) ? max_ab : lim_c;
    assign outer_done = r_phase ? (r_i >= r_len_b) : (r_i >= r_len_a);
    assign pair_hit   = r_phase ? (!r_hit_b && !r_hit_a && r_hit_c)
                                : (!r_hit_a && (r_hit_b ^ r_hit_c));
    assign rd_addr    = (r_state == S_NEXT) ? r_i[AW-1:0] : r_k[AW-1:0];

    tot_list_ram #(.LIST_DEPTH(LIST_DEPTH), .AW(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_len_a[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (rd_addr),
        .o_rdata (rdata_a)
    );

    tot_list_ram #(.LIST_DEPTH(LIST_DEPTH), .AW(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_len_b[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (rd_addr),
        .o_rdata (rdata_b)
    );

    tot_list_ram #(.LIST_DEPTH(LIST_DEPTH), .AW(AW)) u_ram_c (
        .i_clk   (i_clk),
        .i_we    (we_c),
        .i_waddr (r_len_c[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (rd_addr),
        .o_rdata (rdata_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_len_c     <= '0;
            r_drop      <= 1'b0;
            r_phase     <= 1'b0;
            r_i         <= '0;
            r_k         <= '0;
            r_pv        <= 1'b0;
            r_hit_a     <= 1'b0;
            r_hit_b     <= 1'b0;
            r_hit_c     <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;

            // Compare stage: RAM data read in the previous scan cycle.
            if (r_pv) begin
                r_hit_a <= r_hit_a || (r_pen_a && (rdata_a == r_x));
                r_hit_b <= r_hit_b || (r_pen_b && (rdata_b == r_x));
                r_hit_c <= r_hit_c || (r_pen_c && (rdata_c == r_x));
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_mode)
                            tot_pkg::MODE_APPEND_A: begin
                                if (we_a) r_len_a <= r_len_a + 1'b1;
                                else      r_drop  <= 1'b1;
                            end
                            tot_pkg::MODE_APPEND_B: begin
                                if (we_b) r_len_b <= r_len_b + 1'b1;
                                else      r_drop  <= 1'b1;
                            end
                            tot_pkg::MODE_APPEND_C: begin
                                if (we_c) r_len_c <= r_len_c + 1'b1;
                                else      r_drop  <= 1'b1;
                            end
                            tot_pkg::MODE_COMPUTE: begin
                                r_phase <= 1'b0;
                                r_i     <= '0;
                                r_total <= '0;
                                r_state <= S_NEXT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_NEXT: begin
                    if (outer_done) begin
                        if (r_phase) begin
                            r_state <= S_DONE;
                        end else begin
                            r_phase <= 1'b1;
                            r_i     <= '0;
                        end
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_x     <= r_phase ? rdata_b : rdata_a;
                    r_hit_a <= 1'b0;
                    r_hit_b <= 1'b0;
                    r_hit_c <= 1'b0;
                    r_k     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_k < scan_len) begin
                        r_pv    <= 1'b1;
                        r_pen_a <= r_k < lim_a;
                        r_pen_b <= r_k < lim_b;
                        r_pen_c <= r_k < lim_c;
                        r_k     <= r_k + 1'b1;
                    end else begin
                        r_state <= S_TALLY;
                    end
                end
                S_TALLY: begin
                    if (pair_hit && (r_total != tot_pkg::COUNT_MAX)) begin
                        r_total <= r_total + 1'b1;
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= S_NEXT;
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out_count <= r_total;
                    r_out_ovf   <= r_drop;
                    r_len_a     <= '0;
                    r_len_b     <= '0;
                    r_len_c     <= '0;
                    r_drop      <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_pair_count   = r_out_count;
    assign o_overflow     = r_out_ovf;

    `TOT_ASSERT_NEXT(a_done_gives_result, r_state == S_DONE,
        o_result_valid && !busy, "compute finished without a result strobe")
    `TOT_ASSERT_NEXT(a_full_append_flags,
        accept && (i_mode == tot_pkg::MODE_APPEND_A) && (r_len_a == DEPTH_L),
        r_drop && (r_len_a == DEPTH_L), "append to full list A was not flagged")
    `TOT_ASSERT_NOW(a_scan_in_range, r_state == S_SCAN,
        (r_k <= scan_len) && (scan_len <= DEPTH_L), "scan index past its limit")
    `TOT_ASSERT_NOW(a_compare_after_scan, r_pv,
        $past(r_state) == S_SCAN, "compare stage active outside a scan")

endmodule
